@@ src/assert_macros.svh @@
// assertion helper macros for the conveyor motor controller
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// implication check, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/jcmc_pkg.sv @@
// shared types, constants and tables of the conveyor motor controller
// no dependencies; used by every module of the block
package jcmc_pkg;

  localparam int SAMPLE_MAX = 1023;
  localparam int PWM_MAX    = 255;
  localparam int SAMPLE_W   = 10;
  localparam int SPEED_W    = 8;
  localparam int MAG_W      = 7;
  localparam int DZ_W       = 7;
  localparam int DUTY_W     = 8;
  localparam int PCT_MAX    = 100;
  localparam int SCALE_NUM  = 200;
  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(10);

  // sample scaling: q = floor(x*200/SAMPLE_MAX) as one multiply by a rounded-up reciprocal
  localparam longint PROD_MAX  = longint'(2**SAMPLE_W - 1) * SCALE_NUM;
  localparam int     PROD_W    = $clog2(PROD_MAX + 1);
  localparam int     DIV_SHIFT = PROD_W + $clog2(SAMPLE_MAX);
  localparam longint RECIP     = ((longint'(1) << DIV_SHIFT) + SAMPLE_MAX - 1) / SAMPLE_MAX;
  localparam longint SCALE_K   = RECIP * SCALE_NUM;
  localparam int     SCALE_K_W = $clog2(SCALE_K + 1);
  localparam int     QUO_MAX   = int'(PROD_MAX / SAMPLE_MAX);
  localparam int     QUO_W     = $clog2(QUO_MAX + 1);
  localparam int     VAL_W     = ((QUO_W > SPEED_W) ? QUO_W : SPEED_W) + 1;

  localparam int PWM_W = $clog2(PWM_MAX + 1);

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [PWM_W-1:0]          duty_t;
  typedef duty_t                     duty_lut_t [0:2**MAG_W-1];

  localparam speed_t SPEED_HI = SPEED_W'(PCT_MAX);
  localparam speed_t SPEED_LO = -SPEED_HI;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_MANUAL   = 2'd2,
    MODE_CONSTANT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SYM_DASH  = 2'd0,
    SYM_EXCL  = 2'd1,
    SYM_UP    = 2'd2,
    SYM_DOWN  = 2'd3
  } symbol_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic                click;
    logic                long_press;
    speed_t              set_speed;
  } item_t;

  typedef struct packed {
    speed_t  drive;
    symbol_e symbol;
    mode_e   mode;
    speed_t  speed_reading;
  } ctrl_res_t;

  // duty per percent magnitude, |v|*PWM_MAX/100 truncated
  function automatic duty_lut_t build_duty_lut();
    duty_lut_t t;
    for (int i = 0; i < 2**MAG_W; i++) begin
      t[i] = PWM_W'((i * PWM_MAX) / PCT_MAX);
    end
    return t;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

@@ src/jcmc_scale.sv @@
// joystick sample to signed percent speed and its magnitude
// depends on jcmc_pkg
module jcmc_scale (
  input  logic [jcmc_pkg::SAMPLE_W-1:0] sample_i,
  output jcmc_pkg::speed_t              speed_o,
  output jcmc_pkg::mag_t                mag_o
);

  logic [jcmc_pkg::SAMPLE_W+jcmc_pkg::SCALE_K_W-1:0] prod;
  logic [jcmc_pkg::QUO_W-1:0]                         quo;
  logic signed [jcmc_pkg::VAL_W-1:0]                  val;
  jcmc_pkg::speed_t                                   spd;

  assign prod = (jcmc_pkg::SAMPLE_W + jcmc_pkg::SCALE_K_W)'(sample_i)
              * (jcmc_pkg::SAMPLE_W + jcmc_pkg::SCALE_K_W)'(jcmc_pkg::SCALE_K);
  assign quo  = jcmc_pkg::QUO_W'(prod >> jcmc_pkg::DIV_SHIFT);

  always_comb begin
    val = $signed({1'b0, (jcmc_pkg::VAL_W-1)'(quo)})
        - jcmc_pkg::VAL_W'(jcmc_pkg::PCT_MAX);
    // saturate only above; the low end never goes past -100
    if (val > jcmc_pkg::VAL_W'(jcmc_pkg::PCT_MAX)) begin
      spd = jcmc_pkg::SPEED_HI;
    end else begin
      spd = jcmc_pkg::SPEED_W'(val);
    end
  end

  assign speed_o = spd;
  assign mag_o   = spd[jcmc_pkg::SPEED_W-1] ? jcmc_pkg::MAG_W'(-spd)
                                             : jcmc_pkg::MAG_W'(spd);

endmodule

@@ src/jcmc_duty.sv @@
// signed percent drive value to the two pwm leg duties
// depends on jcmc_pkg (duty table)
module jcmc_duty (
  input  jcmc_pkg::speed_t          drive_i,
  output logic [jcmc_pkg::DUTY_W-1:0] fwd_o,
  output logic [jcmc_pkg::DUTY_W-1:0] rev_o
);

  jcmc_pkg::mag_t  mag;
  jcmc_pkg::duty_t duty;

  assign mag  = drive_i[jcmc_pkg::SPEED_W-1] ? jcmc_pkg::MAG_W'(-drive_i)
                                              : jcmc_pkg::MAG_W'(drive_i);
  assign duty = jcmc_pkg::DUTY_LUT[mag];

  always_comb begin
    fwd_o = '0;
    rev_o = '0;
    if (drive_i < 0) begin
      rev_o = jcmc_pkg::DUTY_W'(duty);
    end else if (drive_i != 0) begin
      fwd_o = jcmc_pkg::DUTY_W'(duty);
    end
  end

endmodule

@@ src/jcmc_ctrl.sv @@
// mode state machine, latched button events, held and recorded speeds
// depends on jcmc_pkg
module jcmc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  jcmc_pkg::item_t              item_i,
  input  jcmc_pkg::speed_t             stick_i,
  input  jcmc_pkg::mag_t               stick_mag_i,
  input  logic [jcmc_pkg::DZ_W-1:0]    dead_zone_i,
  output jcmc_pkg::ctrl_res_t          res_o
);

  jcmc_pkg::mode_e   mode_q, mode_d;
  jcmc_pkg::symbol_e sym_q, sym_d;
  jcmc_pkg::speed_t  held_q, held_d;
  jcmc_pkg::speed_t  rec_q, rec_d;
  logic              pclick_q, pclick_d;
  logic              plong_q, plong_d;
  jcmc_pkg::speed_t  drive;
  jcmc_pkg::speed_t  set_sat;
  logic              pc, pl;
  logic              off_center;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= jcmc_pkg::MODE_INACTIVE;
      sym_q    <= jcmc_pkg::SYM_DASH;
      held_q   <= '0;
      rec_q    <= '0;
      pclick_q <= 1'b0;
      plong_q  <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      sym_q    <= sym_d;
      held_q   <= held_d;
      rec_q    <= rec_d;
      pclick_q <= pclick_d;
      plong_q  <= plong_d;
    end
  end

  always_comb begin
    if (item_i.set_speed > jcmc_pkg::SPEED_HI) begin
      set_sat = jcmc_pkg::SPEED_HI;
    end else if (item_i.set_speed < jcmc_pkg::SPEED_LO) begin
      set_sat = jcmc_pkg::SPEED_LO;
    end else begin
      set_sat = item_i.set_speed;
    end
  end

  assign pc         = pclick_q | item_i.click;
  assign pl         = plong_q | item_i.long_press;
  assign off_center = stick_mag_i > dead_zone_i;

  always_comb begin
    mode_d   = mode_q;
    sym_d    = sym_q;
    held_d   = held_q;
    rec_d    = rec_q;
    pclick_d = pclick_q;
    plong_d  = plong_q;
    drive    = '0;
    if (item_i.cmd == jcmc_pkg::CMD_SET) begin
      // events are not latched on a set command
      held_d = set_sat;
      rec_d  = set_sat;
      mode_d = jcmc_pkg::MODE_CONSTANT;
      drive  = set_sat;
    end else begin
      pclick_d = pc;
      plong_d  = pl;
      unique case (mode_q)
        jcmc_pkg::MODE_INACTIVE: begin
          sym_d = jcmc_pkg::SYM_DASH;
          if (pl) begin
            mode_d  = jcmc_pkg::MODE_ARMED;
            plong_d = 1'b0;
          end
        end
        jcmc_pkg::MODE_ARMED: begin
          sym_d    = jcmc_pkg::SYM_EXCL;
          rec_d    = stick_i;
          pclick_d = 1'b0;
          if (pl) begin
            mode_d  = jcmc_pkg::MODE_INACTIVE;
            plong_d = 1'b0;
          end else if (off_center) begin
            mode_d = jcmc_pkg::MODE_MANUAL;
          end
        end
        jcmc_pkg::MODE_MANUAL: begin
          if (!off_center) begin
            // centered: stop, back to armed, symbol and events kept
            mode_d = jcmc_pkg::MODE_ARMED;
          end else begin
            drive = stick_i;
            sym_d = (stick_i < 0) ? jcmc_pkg::SYM_DOWN : jcmc_pkg::SYM_UP;
            if (pl) begin
              mode_d  = jcmc_pkg::MODE_INACTIVE;
              plong_d = 1'b0;
            end else if (pc) begin
              mode_d   = jcmc_pkg::MODE_CONSTANT;
              held_d   = stick_i;
              pclick_d = 1'b0;
            end
          end
        end
        jcmc_pkg::MODE_CONSTANT: begin
          rec_d = held_q;
          drive = held_q;
          if (held_q < 0) begin
            sym_d = jcmc_pkg::SYM_DOWN;
          end else if (held_q != 0) begin
            sym_d = jcmc_pkg::SYM_UP;
          end else begin
            sym_d = jcmc_pkg::SYM_EXCL;
          end
          if (pl) begin
            mode_d  = jcmc_pkg::MODE_INACTIVE;
            plong_d = 1'b0;
          end else if (pc) begin
            mode_d   = jcmc_pkg::MODE_MANUAL;
            pclick_d = 1'b0;
          end
        end
        default: begin
          mode_d = jcmc_pkg::MODE_INACTIVE;
        end
      endcase
    end
  end

  assign res_o.drive         = drive;
  assign res_o.symbol        = sym_d;
  assign res_o.mode          = mode_d;
  assign res_o.speed_reading = rec_d;

endmodule

@@ src/joystick_conveyor_motor_controller.sv @@
// top level of the joystick conveyor motor controller
// depends on jcmc_pkg, jcmc_scale, jcmc_ctrl, jcmc_duty and assert_macros.svh
//
//   channel  handshake                 payload
//   -------  ------------------------  ----------------------------------------------
//   input    in_valid_i / in_ready_o   cmd, joystick_sample, click/long_press events,
//                                      set_speed
//   result   out_valid_o / out_ready_i pwm_forward, pwm_reverse, symbol, mode,
//                                      speed_reading
//   config   cfg_we_i                  cfg_wdata_i (dead zone, no wait, no read-back)
//
// an item is held in the input register, then one pass of scaling,
// mode logic and duty lookup loads the result register
// one item per cycle sustained while out_ready_i stays high; the scaling multiply by the reciprocal sets the path
// the input register keeps taking transfers while a result waits, until both are full
// reset clears the mode state, latched events, speeds and sets the dead zone to 10
`include "assert_macros.svh"

module joystick_conveyor_motor_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [jcmc_pkg::SAMPLE_W-1:0]   joystick_sample_i,
  input  logic                            click_event_i,
  input  logic                            long_press_event_i,
  input  logic signed [jcmc_pkg::SPEED_W-1:0] set_speed_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [jcmc_pkg::DUTY_W-1:0]     pwm_forward_o,
  output logic [jcmc_pkg::DUTY_W-1:0]     pwm_reverse_o,
  output logic [1:0]                      symbol_o,
  output logic [1:0]                      mode_o,
  output logic signed [jcmc_pkg::SPEED_W-1:0] speed_reading_o,
  input  logic                            cfg_we_i,
  input  logic [jcmc_pkg::DZ_W-1:0]       cfg_wdata_i
);

  // dead zone register
  logic [jcmc_pkg::DZ_W-1:0] dz_q;

  // input stage
  logic             in_vld_q;
  jcmc_pkg::item_t  item_q;

  // result stage
  logic                        out_vld_q, out_vld_d;
  logic [jcmc_pkg::DUTY_W-1:0] fwd_q, rev_q;
  jcmc_pkg::symbol_e           sym_q;
  jcmc_pkg::mode_e             mode_q;
  jcmc_pkg::speed_t            rec_q;

  logic                        fire;
  jcmc_pkg::speed_t            stick;
  jcmc_pkg::mag_t              stick_mag;
  jcmc_pkg::ctrl_res_t         res;
  logic [jcmc_pkg::DUTY_W-1:0] fwd, rev;

  // the pass runs when the input stage holds an item and the result slot frees up
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= jcmc_pkg::DZ_RESET;
    end else if (cfg_we_i) begin
      dz_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd        <= jcmc_pkg::cmd_e'(cmd_i);
      item_q.sample     <= joystick_sample_i;
      item_q.click      <= click_event_i;
      item_q.long_press <= long_press_event_i;
      item_q.set_speed  <= set_speed_i;
    end
  end

  jcmc_scale u_scale (
    .sample_i (item_q.sample),
    .speed_o  (stick),
    .mag_o    (stick_mag)
  );

  jcmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .item_i      (item_q),
    .stick_i     (stick),
    .stick_mag_i (stick_mag),
    .dead_zone_i (dz_q),
    .res_o       (res)
  );

  jcmc_duty u_duty (
    .drive_i (res.drive),
    .fwd_o   (fwd),
    .rev_o   (rev)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      fwd_q  <= fwd;
      rev_q  <= rev;
      sym_q  <= res.symbol;
      mode_q <= res.mode;
      rec_q  <= res.speed_reading;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pwm_forward_o   = fwd_q;
  assign pwm_reverse_o   = rev_q;
  assign symbol_o        = sym_q;
  assign mode_o          = mode_q;
  assign speed_reading_o = rec_q;

  // only one motor leg is ever driven
  `ASSERT_IMPLIES(a_one_leg, clk_i, rst_ni, out_valid_o,
                  (pwm_forward_o == '0) || (pwm_reverse_o == '0), "both pwm legs driven")

  // armed means the motor stands still
  `ASSERT_IMPLIES(a_armed_stopped, clk_i, rst_ni,
                  out_valid_o && (mode_o == jcmc_pkg::MODE_ARMED),
                  (pwm_forward_o == '0) && (pwm_reverse_o == '0), "motor driven while armed")

  // a held item moves into an empty result slot in the next cycle
  `ASSERT_RST(a_advance, clk_i, rst_ni, (in_vld_q && !out_vld_q) |=> out_vld_q,
              "input stage did not advance into free result slot")

endmodule
